FILE: design/bdte_pkg.sv
// bdte_pkg: shared types, constants and helper functions for the bcd date converter
// no dependencies; imported by every bdte module and by the top level
`default_nettype none

package bdte_pkg;

  // unix time of 2000-01-01 00:00:00
  localparam logic [32:0] EPOCH_2000   = 33'd946684800;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [15:0] DAYS_PER_YR  = 16'd365;
  localparam logic [13:0] MIN_PER_HR   = 14'd60;
  localparam logic [19:0] SEC_PER_MIN  = 20'd60;
  localparam logic [7:0]  MONTH_FIRST  = 8'd1;
  localparam logic [7:0]  MONTH_LAST   = 8'd12;
  localparam logic [7:0]  MONTH_FEB    = 8'd2;
  localparam logic [7:0]  DAY_FIRST    = 8'd1;
  localparam logic [7:0]  DAY_LAST     = 8'd31;

  // decoded fields after stage 1
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
    logic       bad;
  } dec_t;

  // day count and time of day after stage 2
  typedef struct packed {
    logic [15:0] days;
    logic [13:0] hm;
    logic [7:0]  second;
    logic        bad;
  } cnt_t;

  // scaled parts after stage 3
  typedef struct packed {
    logic [32:0] day_secs;
    logic [32:0] tod_epoch;
    logic        bad;
  } scl_t;

  // per-stage advance enables from the top level
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

  // high nibble times ten plus low nibble, 0..165
  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // cumulative days before each month, index is month minus one
  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/bdte_decode.sv
// bdte_decode: stage 1, bcd decode of all six bytes and range check of month and day
// depends on bdte_pkg
`default_nettype none

module bdte_decode
  import bdte_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic       valid_i,
  input  wire logic [7:0] year_bcd_i,
  input  wire logic [7:0] month_bcd_i,
  input  wire logic [7:0] day_bcd_i,
  input  wire logic [7:0] hour_bcd_i,
  input  wire logic [7:0] minute_bcd_i,
  input  wire logic [7:0] second_bcd_i,
  output logic            valid_o,
  output dec_t            data_o
);

  logic valid_q;
  dec_t data_q;
  dec_t data_d;

  // decode and flag out-of-range month or day
  always_comb begin
    data_d.year   = bcd_decode(year_bcd_i);
    data_d.month  = bcd_decode(month_bcd_i);
    data_d.day    = bcd_decode(day_bcd_i);
    data_d.hour   = bcd_decode(hour_bcd_i);
    data_d.minute = bcd_decode(minute_bcd_i);
    data_d.second = bcd_decode(second_bcd_i);
    data_d.bad    = (data_d.month < MONTH_FIRST) || (data_d.month > MONTH_LAST) ||
                    (data_d.day < DAY_FIRST) || (data_d.day > DAY_LAST);
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/bdte_count.sv
// bdte_count: stage 2, days since 2000-01-01 and hour/minute fold
// depends on bdte_pkg
`default_nettype none

module bdte_count
  import bdte_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic valid_i,
  input  wire dec_t data_i,
  output logic      valid_o,
  output cnt_t      data_o
);

  logic        valid_q;
  cnt_t        data_q;
  cnt_t        data_d;
  logic [3:0]  month_idx;
  logic [8:0]  year_p3;
  logic        leap_add;
  logic [7:0]  month_m1;

  // day count: day + month table + leap day + 365*year + leap years before - 1
  always_comb begin
    month_m1  = data_i.month - MONTH_FIRST;
    month_idx = month_m1[3:0];
    year_p3   = {1'b0, data_i.year} + 9'd3;
    leap_add  = (data_i.month > MONTH_FEB) && (data_i.year[1:0] == 2'd0);
    data_d.days = 16'(data_i.day) + 16'(days_before_month(month_idx)) + 16'(leap_add)
                + 16'(data_i.year) * DAYS_PER_YR + 16'(year_p3[8:2]) - 16'd1;
    data_d.hm     = 14'(data_i.hour) * MIN_PER_HR + 14'(data_i.minute);
    data_d.second = data_i.second;
    data_d.bad    = data_i.bad;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/bdte_scale.sv
// bdte_scale: stage 3, days to seconds and time of day plus epoch base
// depends on bdte_pkg
`default_nettype none

module bdte_scale
  import bdte_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,
  input  wire logic valid_i,
  input  wire cnt_t data_i,
  output logic      valid_o,
  output scl_t      data_o
);

  logic        valid_q;
  scl_t        data_q;
  scl_t        data_d;
  logic [19:0] tod;

  // one 16x17 product and the small time-of-day sum
  always_comb begin
    tod              = 20'(data_i.hm) * SEC_PER_MIN + 20'(data_i.second);
    data_d.day_secs  = 33'(data_i.days) * 33'(SECS_PER_DAY);
    data_d.tod_epoch = EPOCH_2000 + 33'(tod);
    data_d.bad       = data_i.bad;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: design/bdte_sum.sv
// bdte_sum: stage 4, final add with zone offset; holds the output register
// depends on bdte_pkg
`default_nettype none

module bdte_sum
  import bdte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        valid_i,
  input  wire scl_t        data_i,
  input  wire logic [17:0] zone_i,
  output logic             valid_o,
  output logic [32:0]      secs_o,
  output logic             bad_o
);

  logic        valid_q;
  logic [32:0] secs_q;
  logic [32:0] secs_d;
  logic        bad_q;
  logic [32:0] zone_ext;

  // sum wraps at 33 bits; flagged dates give zero
  always_comb begin
    zone_ext = {{15{zone_i[17]}}, zone_i};
    if (data_i.bad) begin
      secs_d = '0;
    end else begin
      secs_d = data_i.day_secs + data_i.tod_epoch + zone_ext;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      secs_q <= secs_d;
      bad_q  <= data_i.bad;
    end
  end

  assign valid_o = valid_q;
  assign secs_o  = secs_q;
  assign bad_o   = bad_q;

endmodule

`default_nettype wire

FILE: design/bcd_date_to_epoch_seconds_core.sv
// bcd_date_to_epoch_seconds_core: top level of the bcd date to unix seconds converter
// depends on bdte_pkg, bdte_decode, bdte_count, bdte_scale, bdte_sum
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   six bcd bytes
//   out      result     out_valid_o / out_stall_i unix_seconds_o, bad_date_o
//   cfg      write      cfg_valid_i / cfg_ready_o cfg_data_i (zone offset, 18b signed)
//
// four register stages: decode, day count, scale, final sum (output register).
// a request passes the decode, day count, scale and sum registers in turn before its result shows on the output;
// one request is taken per cycle when the output is not stalled.
// each stage advances when it is empty or the stage after it advances, so bubbles
// close up under stall and in_stall_o rises only when all four stages are full.
// reset clears all stage valids and sets the zone offset to zero.
`default_nettype none

module bcd_date_to_epoch_seconds_core
  import bdte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  year_bcd_i,
  input  wire logic [7:0]  month_bcd_i,
  input  wire logic [7:0]  day_bcd_i,
  input  wire logic [7:0]  hour_bcd_i,
  input  wire logic [7:0]  minute_bcd_i,
  input  wire logic [7:0]  second_bcd_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [32:0]      unix_seconds_o,
  output logic             bad_date_o,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [17:0] cfg_data_i
);

  logic        cfg_write;
  logic [17:0] zone_offset_q;
  adv_t        adv;
  logic        v1;
  logic        v2;
  logic        v3;
  dec_t        d1;
  cnt_t        d2;
  scl_t        d3;

  // zone offset register, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_offset_q <= '0;
    end else if (cfg_write) begin
      zone_offset_q <= cfg_data_i;
    end
  end

  // stage advance chain
  always_comb begin
    adv.s4 = !out_valid_o || !out_stall_i;
    adv.s3 = !v3 || adv.s4;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_stall_o = !adv.s1;

  bdte_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv.s1),
    .valid_i      (in_valid_i),
    .year_bcd_i   (year_bcd_i),
    .month_bcd_i  (month_bcd_i),
    .day_bcd_i    (day_bcd_i),
    .hour_bcd_i   (hour_bcd_i),
    .minute_bcd_i (minute_bcd_i),
    .second_bcd_i (second_bcd_i),
    .valid_o      (v1),
    .data_o       (d1)
  );

  bdte_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv.s2),
    .valid_i (v1),
    .data_i  (d1),
    .valid_o (v2),
    .data_o  (d2)
  );

  bdte_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv.s3),
    .valid_i (v2),
    .data_i  (d2),
    .valid_o (v3),
    .data_o  (d3)
  );

  bdte_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv.s4),
    .valid_i (v3),
    .data_i  (d3),
    .zone_i  (zone_offset_q),
    .valid_o (out_valid_o),
    .secs_o  (unix_seconds_o),
    .bad_o   (bad_date_o)
  );

endmodule

`default_nettype wire
